>>> design/tct_pkg.sv
// Shared types, codes and the per-leg TCP state step for the connection tracker.
// No dependencies; tct_step and tcp_connection_tracker import this package.
`default_nettype none

package tct_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int TIME_BITS_DEF     = 32;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_SYN,
        ST_SYNACK,
        ST_EST,
        ST_FIN,
        ST_ONLYACK,
        ST_FINACK,
        ST_CLOSED
    } leg_state_t;

    typedef enum logic [1:0] {
        V_ACCEPT,
        V_DROP,
        V_NOTFOUND,
        V_REFUSED
    } verdict_t;

    typedef enum logic {
        CMD_CHECK,
        CMD_CREATE
    } command_t;

    localparam logic [1:0] FROM_CLIENT       = 2'd0;
    localparam logic [1:0] FROM_SERVER       = 2'd1;
    localparam logic [1:0] FROM_PROXY_CLIENT = 2'd2;
    localparam logic [1:0] FROM_PROXY_SERVER = 2'd3;

    typedef struct packed {
        leg_state_t state;
        logic [1:0] initiator;
    } leg_t;

    typedef struct packed {
        leg_t plain;
        leg_t client;
        leg_t server;
    } legs_t;

    localparam int LEGS_W = $bits(legs_t);

    localparam legs_t LEGS_RESET = '{
        plain:  '{state: ST_NONE, initiator: FROM_CLIENT},
        client: '{state: ST_NONE, initiator: FROM_CLIENT},
        server: '{state: ST_NONE, initiator: FROM_PROXY_CLIENT}
    };

    typedef struct packed {
        command_t   command;
        logic       in_range;
        logic       found;
        logic [1:0] side;
        logic       proxy;
        logic       syn;
        logic       ack;
        logic       fin;
        logic       rst;
    } item_t;

    typedef struct packed {
        verdict_t   verdict;
        leg_state_t state;
        logic       refreshed;
        logic       write;
    } step_res_t;

    typedef struct packed {
        logic accept;
        leg_t leg;
    } leg_step_t;

    function automatic leg_step_t leg_step(leg_t cur, logic [1:0] side,
                                           logic syn, logic ack, logic fin, logic rst);
        logic      from_init;
        leg_step_t r;
        from_init = (side == cur.initiator);
        r.accept  = 1'b0;
        r.leg     = cur;
        if (rst)
        begin
            r.leg.state = ST_CLOSED;
            r.accept    = 1'b1;
        end
        else
        begin
            case (cur.state)
                ST_NONE:
                begin
                    if (from_init && syn && !ack)
                    begin
                        r.leg.state = ST_SYN;
                        r.accept    = 1'b1;
                    end
                end
                ST_SYN:
                begin
                    if (!from_init && syn && ack)
                    begin
                        r.leg.state = ST_SYNACK;
                        r.accept    = 1'b1;
                    end
                end
                ST_SYNACK:
                begin
                    if (from_init && ack)
                    begin
                        r.leg.state = ST_EST;
                        r.accept    = 1'b1;
                    end
                end
                ST_EST:
                begin
                    r.accept = 1'b1;
                    if (fin)
                    begin
                        r.leg.state     = ST_FIN;
                        r.leg.initiator = side;
                    end
                end
                ST_FIN:
                begin
                    if (!from_init && ack)
                    begin
                        r.leg.state = fin ? ST_FINACK : ST_ONLYACK;
                        r.accept    = 1'b1;
                    end
                end
                ST_ONLYACK:
                begin
                    r.accept = 1'b1;
                    if (!from_init && fin)
                    begin
                        r.leg.state = ST_FINACK;
                    end
                end
                ST_FINACK:
                begin
                    if (from_init && ack)
                    begin
                        r.leg.state = ST_CLOSED;
                        r.accept    = 1'b1;
                    end
                end
                ST_CLOSED:
                begin
                    r.accept = 1'b0;
                end
                default:
                begin
                    r.accept = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/tct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/tct_step.sv
// Combinational update of one table entry for a check or create beat.
// Depends on tct_pkg for the item, entry and result types and the leg step.
`default_nettype none

module tct_step #(
    parameter int TIME_BITS = tct_pkg::TIME_BITS_DEF
) (
    input  tct_pkg::item_t       item,
    input  logic [TIME_BITS-1:0] now,
    input  tct_pkg::legs_t       legs,
    input  logic [TIME_BITS-1:0] seen,
    output tct_pkg::step_res_t   res,
    output tct_pkg::legs_t       new_legs,
    output logic [TIME_BITS-1:0] new_seen,
    output logic [31:0]          last_seen
);

    import tct_pkg::*;

    leg_t      cur_leg;
    leg_t      open_leg;
    leg_step_t stp;
    logic      client_leg_sel;

    always_comb
    begin
        client_leg_sel = (item.side == FROM_CLIENT) || (item.side == FROM_PROXY_SERVER);
        if (!item.proxy)
        begin
            cur_leg = legs.plain;
        end
        else if (client_leg_sel)
        begin
            cur_leg = legs.client;
        end
        else
        begin
            cur_leg = legs.server;
        end
        open_leg = item.proxy ? legs.client : legs.plain;
        stp = leg_step(cur_leg, item.side, item.syn, item.ack, item.fin, item.rst);

        new_legs      = legs;
        new_seen      = seen;
        last_seen     = '0;
        res.verdict   = V_NOTFOUND;
        res.state     = ST_NONE;
        res.refreshed = 1'b0;
        res.write     = 1'b0;

        if (!item.in_range)
        begin
            res.verdict = (item.command == CMD_CREATE) ? V_REFUSED : V_NOTFOUND;
        end
        else if (item.command == CMD_CREATE)
        begin
            if (item.ack)
            begin
                res.verdict = V_REFUSED;
                res.state   = open_leg.state;
                last_seen   = 32'(seen);
            end
            else
            begin
                new_legs = LEGS_RESET;
                if (item.proxy)
                begin
                    new_legs.client.state = ST_SYN;
                end
                else
                begin
                    new_legs.plain.state = ST_SYN;
                end
                new_seen      = now;
                res.verdict   = V_ACCEPT;
                res.state     = ST_SYN;
                res.refreshed = 1'b1;
                res.write     = 1'b1;
                last_seen     = 32'(now);
            end
        end
        else if (item.found)
        begin
            res.state = stp.leg.state;
            if (stp.accept)
            begin
                if (!item.proxy)
                begin
                    new_legs.plain = stp.leg;
                end
                else if (client_leg_sel)
                begin
                    new_legs.client = stp.leg;
                end
                else
                begin
                    new_legs.server = stp.leg;
                end
                new_seen      = now;
                res.verdict   = V_ACCEPT;
                res.refreshed = 1'b1;
                res.write     = 1'b1;
                last_seen     = 32'(now);
            end
            else
            begin
                res.verdict = V_DROP;
                last_seen   = 32'(seen);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/tcp_connection_tracker.sv
// Top level of the TCP connection tracker: entry table, read-modify-write pipeline
// and result register. Depends on tct_pkg, tct_ram and tct_step.
//
//   Channel  Signals                                                Direction
//   in       in_valid/in_ready, command, conn_index, entry_found,   sink
//            packet_side, proxy_mode, flag_syn/ack/fin/rst, now_time
//   out      out_valid/out_ready, verdict, leg_state_after,         source
//            refreshed, last_seen
//
// One beat is taken per cycle while the output is not stalled. The entry read issued
// at acceptance returns in the next cycle, where the update is computed and written
// back; a back-to-back beat to the same entry takes the written value from a bypass
// register. After reset a clearing pass writes every entry, one per cycle, while
// in_ready is low.
// A stalled output holds the pipeline and drops in_ready once the middle stage is full.
`default_nettype none

module tcp_connection_tracker #(
    parameter int TABLE_ENTRIES = tct_pkg::TABLE_ENTRIES_DEF,
    parameter int TIME_BITS     = tct_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  conn_index,
    input  logic        entry_found,
    input  logic [1:0]  packet_side,
    input  logic        proxy_mode,
    input  logic        flag_syn,
    input  logic        flag_ack,
    input  logic        flag_fin,
    input  logic        flag_rst,
    input  logic [31:0] now_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  verdict,
    output logic [2:0]  leg_state_after,
    output logic        refreshed,
    output logic [31:0] last_seen
);

    import tct_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = LEGS_W + TIME_BITS;

    logic                 clearing_reg, clearing_next;
    logic [IDX_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 byp_valid_reg, byp_valid_next;
    logic                 out_valid_reg, out_valid_next;
    item_t                s1_item_reg;
    logic [TIME_BITS-1:0] s1_now_reg;
    logic [IDX_W-1:0]     s1_addr_reg;
    logic [ENTRY_W-1:0]   byp_data_reg;
    verdict_t             verdict_reg;
    leg_state_t           state_reg;
    logic                 refreshed_reg;
    logic [31:0]          last_seen_reg;

    item_t                in_item;
    logic [IDX_W-1:0]     in_addr;
    logic                 advance;
    logic                 s1_go;
    logic                 accept;
    logic [ENTRY_W-1:0]   rd_data;
    logic [ENTRY_W-1:0]   cur_entry;
    legs_t                cur_legs;
    logic [TIME_BITS-1:0] cur_seen;
    step_res_t            res;
    legs_t                new_legs;
    logic [TIME_BITS-1:0] new_seen;
    logic [31:0]          step_last_seen;
    logic [ENTRY_W-1:0]   upd_entry;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;

    always_comb
    begin
        in_item.command  = command_t'(command);
        in_item.in_range = (32'(conn_index) < 32'(TABLE_ENTRIES));
        in_item.found    = entry_found;
        in_item.side     = packet_side;
        in_item.proxy    = proxy_mode;
        in_item.syn      = flag_syn;
        in_item.ack      = flag_ack;
        in_item.fin      = flag_fin;
        in_item.rst      = flag_rst;
    end

    assign in_addr  = IDX_W'(conn_index);
    assign advance  = !out_valid_reg || out_ready;
    assign s1_go    = s1_valid_reg && advance;
    assign in_ready = !clearing_reg && (!s1_valid_reg || advance);
    assign accept   = in_valid && in_ready;

    assign cur_entry = byp_valid_reg ? byp_data_reg : rd_data;
    assign cur_legs  = legs_t'(cur_entry[ENTRY_W-1:TIME_BITS]);
    assign cur_seen  = cur_entry[TIME_BITS-1:0];
    assign upd_entry = {new_legs, new_seen};

    assign wr_en   = clearing_reg || (s1_go && res.write);
    assign wr_addr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign wr_data = clearing_reg ? {LEGS_RESET, {TIME_BITS{1'b0}}} : upd_entry;

    tct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rd_data)
    );

    tct_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .item      (s1_item_reg),
        .now       (s1_now_reg),
        .legs      (cur_legs),
        .seen      (cur_seen),
        .res       (res),
        .new_legs  (new_legs),
        .new_seen  (new_seen),
        .last_seen (step_last_seen)
    );

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == IDX_W'(TABLE_ENTRIES - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

        byp_valid_next = byp_valid_reg;
        if (accept)
        begin
            byp_valid_next = s1_go && res.write && (s1_addr_reg == in_addr);
        end
        else if (s1_go)
        begin
            byp_valid_next = 1'b0;
        end

        out_valid_next = s1_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            byp_valid_reg <= byp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= in_item;
            s1_now_reg   <= TIME_BITS'(now_time);
            s1_addr_reg  <= in_addr;
            byp_data_reg <= upd_entry;
        end
        if (s1_go)
        begin
            verdict_reg   <= res.verdict;
            state_reg     <= res.state;
            refreshed_reg <= res.refreshed;
            last_seen_reg <= step_last_seen;
        end
    end

    assign out_valid       = out_valid_reg;
    assign verdict         = verdict_reg;
    assign leg_state_after = state_reg;
    assign refreshed       = refreshed_reg;
    assign last_seen       = last_seen_reg;

    // No item may occupy the pipeline while the table is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg && !in_ready)
        else $error("item in flight during clearing pass");

    // The bypass register only serves an item that is waiting in the middle stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        byp_valid_reg |-> s1_valid_reg)
        else $error("bypass valid without a pending item");

    // The time stamp is refreshed exactly on an accepted beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (refreshed == (verdict == V_ACCEPT)))
        else $error("refresh flag disagrees with verdict");

    // A not-found result carries no state and no time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verdict == V_NOTFOUND) |-> (leg_state_after == ST_NONE)
            && (last_seen == 32'd0))
        else $error("not-found result carries data");

    // A result leaves the middle stage only into an empty or draining output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && s1_valid_reg) |=> s1_valid_reg)
        else $error("middle stage lost an item under output stall");

endmodule

`default_nettype wire

>>> tb/sv/tb_tcp_connection_tracker.sv
// Self-checking testbench for tcp_connection_tracker: drives packet and create beats
// with random gaps and stalls, and checks every result against an in-bench tracker model.
// Depends on tct_pkg and the tcp_connection_tracker RTL.
`timescale 1ns / 100ps

module tb_tcp_connection_tracker;

    import tct_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int DRAIN_AT      = 500;
    localparam int CALM_FROM     = 900;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 40;
    localparam int SETTLE_CYCLES = 10;

    typedef enum int {
        LEG_PLAIN,
        LEG_CLIENT,
        LEG_SERVER
    } leg_sel_t;

    typedef struct packed {
        command_t    command;
        logic [7:0]  idx;
        logic        found;
        logic [1:0]  side;
        logic        proxy;
        logic        syn;
        logic        ack;
        logic        fin;
        logic        rst;
        logic [31:0] stamp;
        logic        drain_first;
        logic        calm;
    } pkt_t;

    typedef struct packed {
        verdict_t    verdict;
        leg_state_t  state;
        logic        refreshed;
        logic [31:0] seen;
    } outcome_t;

    typedef struct packed {
        logic ok;
        leg_t leg;
    } leg_move_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = 1'b0;
    logic [7:0]  conn_index = '0;
    logic        entry_found = 1'b0;
    logic [1:0]  packet_side = '0;
    logic        proxy_mode = 1'b0;
    logic        flag_syn = 1'b0;
    logic        flag_ack = 1'b0;
    logic        flag_fin = 1'b0;
    logic        flag_rst = 1'b0;
    logic [31:0] now_time = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  verdict;
    logic [2:0]  leg_state_after;
    logic        refreshed;
    logic [31:0] last_seen;

    leg_t        leg_tbl[3][256];
    logic [31:0] stamp_tbl[256];

    pkt_t        packet_backlog[$];
    outcome_t    awaited_outcomes[$];
    pkt_t        cur_pkt;
    logic        quiet_tail = 1'b0;
    logic        session_cut;
    int          queued = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          dull_cycles = 0;

    tcp_connection_tracker i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .conn_index      (conn_index),
        .entry_found     (entry_found),
        .packet_side     (packet_side),
        .proxy_mode      (proxy_mode),
        .flag_syn        (flag_syn),
        .flag_ack        (flag_ack),
        .flag_fin        (flag_fin),
        .flag_rst        (flag_rst),
        .now_time        (now_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .verdict         (verdict),
        .leg_state_after (leg_state_after),
        .refreshed       (refreshed),
        .last_seen       (last_seen)
    );

    always #5 clk = ~clk;

    function automatic void clear_entry(int i);
        leg_tbl[LEG_PLAIN][i]  = '{state: ST_NONE, initiator: FROM_CLIENT};
        leg_tbl[LEG_CLIENT][i] = '{state: ST_NONE, initiator: FROM_CLIENT};
        leg_tbl[LEG_SERVER][i] = '{state: ST_NONE, initiator: FROM_PROXY_CLIENT};
        stamp_tbl[i] = '0;
    endfunction

    function automatic leg_move_t advance_leg(leg_t lg, logic [1:0] side,
                                              logic syn, logic ack, logic fin, logic rst);
        leg_move_t m;
        logic      mine;
        mine  = (side == lg.initiator);
        m.leg = lg;
        m.ok  = 1'b0;
        if (rst)
        begin
            m.leg.state = ST_CLOSED;
            m.ok        = 1'b1;
        end
        else
        begin
            case (lg.state)
                ST_NONE:    m.ok = mine && syn && !ack;
                ST_SYN:     m.ok = !mine && syn && ack;
                ST_SYNACK:  m.ok = mine && ack;
                ST_EST:     m.ok = 1'b1;
                ST_FIN:     m.ok = !mine && ack;
                ST_ONLYACK: m.ok = 1'b1;
                ST_FINACK:  m.ok = mine && ack;
                default:    m.ok = 1'b0;
            endcase
            if (m.ok)
            begin
                case (lg.state)
                    ST_NONE:   m.leg.state = ST_SYN;
                    ST_SYN:    m.leg.state = ST_SYNACK;
                    ST_SYNACK: m.leg.state = ST_EST;
                    ST_EST:
                    begin
                        if (fin)
                        begin
                            m.leg.state     = ST_FIN;
                            m.leg.initiator = side;
                        end
                    end
                    ST_FIN:    m.leg.state = fin ? ST_FINACK : ST_ONLYACK;
                    ST_ONLYACK:
                    begin
                        if (!mine && fin)
                        begin
                            m.leg.state = ST_FINACK;
                        end
                    end
                    ST_FINACK: m.leg.state = ST_CLOSED;
                    default:   m.leg.state = lg.state;
                endcase
            end
        end
        return m;
    endfunction

    function automatic outcome_t track_packet(pkt_t p);
        outcome_t  o;
        leg_move_t m;
        leg_sel_t  sel;
        o = '{verdict: V_NOTFOUND, state: ST_NONE, refreshed: 1'b0, seen: '0};
        if (p.command == CMD_CREATE)
        begin
            sel = p.proxy ? LEG_CLIENT : LEG_PLAIN;
            if (p.ack)
            begin
                o.verdict = V_REFUSED;
                o.state   = leg_tbl[sel][p.idx].state;
                o.seen    = stamp_tbl[p.idx];
            end
            else
            begin
                clear_entry(p.idx);
                leg_tbl[sel][p.idx].state = ST_SYN;
                stamp_tbl[p.idx] = p.stamp;
                o = '{verdict: V_ACCEPT, state: ST_SYN, refreshed: 1'b1, seen: p.stamp};
            end
        end
        else if (p.found)
        begin
            if (!p.proxy)
                sel = LEG_PLAIN;
            else if (p.side == FROM_CLIENT || p.side == FROM_PROXY_SERVER)
                sel = LEG_CLIENT;
            else
                sel = LEG_SERVER;
            m = advance_leg(leg_tbl[sel][p.idx], p.side, p.syn, p.ack, p.fin, p.rst);
            leg_tbl[sel][p.idx] = m.leg;
            if (m.ok)
            begin
                stamp_tbl[p.idx] = p.stamp;
                o.verdict   = V_ACCEPT;
                o.refreshed = 1'b1;
            end
            else
            begin
                o.verdict = V_DROP;
            end
            o.state = m.leg.state;
            o.seen  = stamp_tbl[p.idx];
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch in %s at result %0d: got %0h, expected %0h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic add_pkt(command_t cmd, logic [7:0] idx, logic found, logic [1:0] side,
                           logic proxy, logic syn, logic ack, logic fin, logic rst,
                           logic [31:0] stamp);
        pkt_t p;
        p = '{command: cmd, idx: idx, found: found, side: side, proxy: proxy,
              syn: syn, ack: ack, fin: fin, rst: rst, stamp: stamp,
              drain_first: (queued == DRAIN_AT), calm: (queued >= CALM_FROM)};
        packet_backlog.push_back(p);
        queued++;
    endtask

    task automatic add_noise(logic [7:0] idx);
        command_t cmd;
        cmd = ($urandom_range(0, 7) == 0) ? CMD_CREATE : CMD_CHECK;
        add_pkt(cmd, idx, $urandom_range(0, 3) != 0, 2'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 3) == 0, $urandom());
    endtask

    task automatic add_step(logic [7:0] idx, logic proxy, logic [1:0] side,
                            logic syn, logic ack, logic fin);
        if (session_cut)
            return;
        if ($urandom_range(0, 24) == 0)
        begin
            add_pkt(CMD_CHECK, idx, 1'b1, 2'($urandom_range(0, 3)), proxy,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b1, $urandom());
            session_cut = 1'b1;
            return;
        end
        if ($urandom_range(0, 15) == 0)
            add_noise(idx);
        add_pkt(CMD_CHECK, idx, 1'b1, side, proxy, syn, ack, fin, 1'b0, $urandom());
    endtask

    task automatic add_leg_session(logic [7:0] idx, logic proxy, logic [1:0] opener,
                                   logic [1:0] answerer, logic opened);
        logic [1:0] closer;
        logic [1:0] peer;
        int         chatter;
        session_cut = 1'b0;
        if (!opened)
            add_step(idx, proxy, opener, 1'b1, 1'b0, 1'b0);
        add_step(idx, proxy, answerer, 1'b1, 1'b1, 1'b0);
        add_step(idx, proxy, opener, 1'b0, 1'b1, 1'b0);
        chatter = $urandom_range(0, 4);
        repeat (chatter)
            add_step(idx, proxy, $urandom_range(0, 1) ? opener : answerer,
                     1'b0, 1'b1, 1'b0);
        closer = $urandom_range(0, 1) ? opener : answerer;
        peer   = (closer == opener) ? answerer : opener;
        add_step(idx, proxy, closer, 1'b0, 1'b1, 1'b1);
        if ($urandom_range(0, 1))
        begin
            add_step(idx, proxy, peer, 1'b0, 1'b1, 1'b0);
            if ($urandom_range(0, 1))
                add_step(idx, proxy, closer, 1'b0, 1'b1, 1'b0);
            add_step(idx, proxy, peer, 1'b0, 1'b1, 1'b1);
        end
        else
        begin
            add_step(idx, proxy, peer, 1'b0, 1'b1, 1'b1);
        end
        add_step(idx, proxy, closer, 1'b0, 1'b1, 1'b0);
        if ($urandom_range(0, 3) == 0)
            add_step(idx, proxy, peer, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic add_flow();
        logic [7:0] idx;
        logic       proxy;
        idx   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 7));
        proxy = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
            add_noise(8'($urandom_range(0, 255)));
        add_pkt(CMD_CREATE, idx, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), proxy,
                $urandom_range(0, 3) != 0, 1'b0, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), $urandom());
        if (!proxy)
        begin
            add_leg_session(idx, 1'b0, FROM_CLIENT, FROM_SERVER, 1'b1);
        end
        else
        begin
            add_leg_session(idx, 1'b1, FROM_CLIENT, FROM_PROXY_SERVER, 1'b1);
            add_leg_session(idx, 1'b1, FROM_PROXY_CLIENT, FROM_SERVER, 1'b0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pkt_t nxt;
        logic take;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            take = in_valid && in_ready;
            if (take)
                awaited_outcomes.push_back(track_packet(cur_pkt));
            if (take || !in_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (packet_backlog.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (packet_backlog[0].drain_first && awaited_outcomes.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!packet_backlog[0].calm && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(0, 5);
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = packet_backlog.pop_front();
                    cur_pkt     <= nxt;
                    quiet_tail  <= nxt.calm;
                    command     <= nxt.command;
                    conn_index  <= nxt.idx;
                    entry_found <= nxt.found;
                    packet_side <= nxt.side;
                    proxy_mode  <= nxt.proxy;
                    flag_syn    <= nxt.syn;
                    flag_ack    <= nxt.ack;
                    flag_fin    <= nxt.fin;
                    flag_rst    <= nxt.rst;
                    now_time    <= nxt.stamp;
                    in_valid    <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (awaited_outcomes.size() == 0)
                begin
                    report_mismatch("result with nothing awaited", 32'(verdict), '0);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (verdict !== want.verdict)
                        report_mismatch("verdict", 32'(verdict), 32'(want.verdict));
                    if (leg_state_after !== want.state)
                        report_mismatch("leg_state_after", 32'(leg_state_after),
                                        32'(want.state));
                    if (refreshed !== want.refreshed)
                        report_mismatch("refreshed", 32'(refreshed), 32'(want.refreshed));
                    if (last_seen !== want.seen)
                        report_mismatch("last_seen", last_seen, want.seen);
                end
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            dull_cycles = 0;
        end
        else if (dull_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            dull_cycles++;
        end
    end

    initial
    begin
        for (int i = 0; i < 256; i++)
            clear_entry(i);

        add_pkt(CMD_CREATE, 8'd0, 1'b0, FROM_CLIENT, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_CLIENT, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd1);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_SERVER, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd2);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_CLIENT, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd3);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_CLIENT, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd4);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_SERVER, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 32'd5);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_SERVER, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd6);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_CLIENT, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 32'd7);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_SERVER, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd8);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_CLIENT, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd9);
        add_pkt(CMD_CHECK, 8'd0, 1'b1, FROM_CLIENT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 32'd10);
        add_pkt(CMD_CREATE, 8'd255, 1'b1, FROM_SERVER, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
                32'hFFFF_FFFF);
        add_pkt(CMD_CHECK, 8'd255, 1'b1, FROM_PROXY_SERVER, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                32'h8000_0000);
        add_pkt(CMD_CHECK, 8'd255, 1'b1, FROM_CLIENT, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                32'h7FFF_FFFF);
        add_pkt(CMD_CHECK, 8'd255, 1'b1, FROM_PROXY_CLIENT, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                32'h5555_5555);
        add_pkt(CMD_CHECK, 8'd255, 1'b1, FROM_SERVER, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                32'hAAAA_AAAA);
        add_pkt(CMD_CHECK, 8'd255, 1'b1, FROM_PROXY_CLIENT, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                32'd100);
        add_pkt(CMD_CHECK, 8'd255, 1'b1, FROM_SERVER, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                32'd101);
        add_pkt(CMD_CHECK, 8'd255, 1'b1, FROM_PROXY_CLIENT, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                32'd102);
        add_pkt(CMD_CHECK, 8'd255, 1'b1, FROM_PROXY_CLIENT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                32'd103);
        add_pkt(CMD_CHECK, 8'd255, 1'b1, FROM_SERVER, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                32'd104);
        add_pkt(CMD_CREATE, 8'd255, 1'b1, FROM_CLIENT, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                32'd105);
        add_pkt(CMD_CHECK, 8'd7, 1'b0, FROM_PROXY_SERVER, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                32'd106);
        add_pkt(CMD_CHECK, 8'd100, 1'b1, FROM_SERVER, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                32'd107);
        add_pkt(CMD_CREATE, 8'd100, 1'b0, FROM_PROXY_CLIENT, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                32'd108);

        while (queued < 25 + RANDOM_ITEMS)
            add_flow();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (packet_backlog.size() != 0 || in_valid || awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
design/tct_pkg.sv
design/tct_ram.sv
design/tct_step.sv
design/tcp_connection_tracker.sv
tb/sv/tb_tcp_connection_tracker.sv
